### rtl/srpq_pkg.sv
// Shared types and constants for the sorted runtime priority queue.
package srpq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 32;

  localparam int OP_W     = 2;
  localparam int TASK_W   = 4;
  localparam int RT_W     = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int S_DATA_W = ((TASK_W + RT_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((TASK_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Operation strobes broadcast to every cell of the row.
  typedef struct packed {
    logic ins_en;
    logic pop_en;
    logic rem_en;
  } cell_ctl_t;

endpackage

### rtl/srpq_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
module srpq_cell #(
  parameter int KEY_BITS = srpq_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  srpq_pkg::cell_ctl_t         ctl,
  input  logic [srpq_pkg::TASK_W-1:0] new_task,
  input  logic [KEY_BITS-1:0]         new_key,
  input  logic                        left_valid,
  input  logic [srpq_pkg::TASK_W-1:0] left_task,
  input  logic [KEY_BITS-1:0]         left_key,
  input  logic                        left_le,
  input  logic                        right_valid,
  input  logic [srpq_pkg::TASK_W-1:0] right_task,
  input  logic [KEY_BITS-1:0]         right_key,
  input  logic                        found_in,
  output logic                        valid,
  output logic [srpq_pkg::TASK_W-1:0] task_id,
  output logic [KEY_BITS-1:0]         key,
  output logic                        ins_le,
  output logic                        found_out
);
  import srpq_pkg::*;

  logic                valid_next;
  logic [TASK_W-1:0]   task_next;
  logic [KEY_BITS-1:0] key_next;
  logic                match;

  assign match     = valid && (task_id == new_task);
  assign found_out = found_in | match;
  // The row is sorted, so this flag is false before the insert point and true from it on.
  assign ins_le    = !valid || (new_key <= key);

  always_comb begin
    priority if (ctl.ins_en && ins_le) begin
      if (left_le) begin
        valid_next = left_valid;
        task_next  = left_task;
        key_next   = left_key;
      end else begin
        valid_next = 1'b1;
        task_next  = new_task;
        key_next   = new_key;
      end
    end else if (ctl.pop_en || (ctl.rem_en && found_out)) begin
      valid_next = right_valid;
      task_next  = right_task;
      key_next   = right_key;
    end else begin
      valid_next = valid;
      task_next  = task_id;
      key_next   = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    task_id <= task_next;
    key     <= key_next;
  end

endmodule

### rtl/sorted_runtime_priority_queue.sv
// Top level of the sorted runtime priority queue built from a row of shifting cells.
// The result of an accepted request is registered and presented in the next cycle.
// Throughput: one request per cycle unless the output stalls; all cells compare and shift
// in the same cycle, and the remove search ripples its first-match flag through the row.
// Reset clears the entry count and all cell valid bits at once; no clearing pass.
module sorted_runtime_priority_queue #(
  parameter int QUEUE_DEPTH = srpq_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = srpq_pkg::DEF_KEY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [srpq_pkg::S_DATA_W-1:0] s_tdata,   // task_id, runtime_key, zero fill
  input  logic [srpq_pkg::OP_W-1:0]     s_tuser,   // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [srpq_pkg::M_DATA_W-1:0] m_tdata,   // popped_task, entry_count, zero fill
  output logic [srpq_pkg::STATUS_W-1:0] m_tuser    // status
);
  import srpq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  op_t                 op;
  logic [TASK_W-1:0]   in_task;
  logic [RT_W-1:0]     in_rt;
  logic [KEY_BITS-1:0] in_key;
  logic [RT_W+KEY_BITS-1:0] rt_ext;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             empty;
  cell_ctl_t        ctl;
  status_t          status_next;

  logic                valid_c [QUEUE_DEPTH];
  logic [TASK_W-1:0]   task_c  [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] key_c   [QUEUE_DEPTH];
  logic                le_c    [QUEUE_DEPTH];
  logic                found_c [QUEUE_DEPTH];

  status_t            status;
  logic [TASK_W-1:0]  popped;
  logic [CNT_W-1:0]   count_out;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign op      = op_t'(s_tuser);
  assign in_task = s_tdata[TASK_W-1:0];
  assign in_rt   = s_tdata[TASK_W+RT_W-1:TASK_W];
  // Keep only the low KEY_BITS bits of the runtime, zero extended when wider.
  assign rt_ext  = {{KEY_BITS{1'b0}}, in_rt};
  assign in_key  = rt_ext[KEY_BITS-1:0];

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = ST_DONE;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctl.ins_en = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_POP: begin
          if (empty) begin
            status_next = ST_MISS;
          end else begin
            ctl.pop_en = 1'b1;
            count_next = count - 1'b1;
          end
        end
        OP_REMOVE: begin
          ctl.rem_en = 1'b1;
          if (found_c[QUEUE_DEPTH-1]) begin
            count_next = count - 1'b1;
          end else begin
            status_next = ST_MISS;
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                l_valid;
    logic [TASK_W-1:0]   l_task;
    logic [KEY_BITS-1:0] l_key;
    logic                l_le;
    logic                r_valid;
    logic [TASK_W-1:0]   r_task;
    logic [KEY_BITS-1:0] r_key;
    logic                f_in;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_task  = '0;
      assign l_key   = '0;
      assign l_le    = 1'b0;
      assign f_in    = 1'b0;
    end else begin : g_body
      assign l_valid = valid_c[i-1];
      assign l_task  = task_c[i-1];
      assign l_key   = key_c[i-1];
      assign l_le    = le_c[i-1];
      assign f_in    = found_c[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_task  = '0;
      assign r_key   = '0;
    end else begin : g_mid
      assign r_valid = valid_c[i+1];
      assign r_task  = task_c[i+1];
      assign r_key   = key_c[i+1];
    end

    srpq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_task    (in_task),
      .new_key     (in_key),
      .left_valid  (l_valid),
      .left_task   (l_task),
      .left_key    (l_key),
      .left_le     (l_le),
      .right_valid (r_valid),
      .right_task  (r_task),
      .right_key   (r_key),
      .found_in    (f_in),
      .valid       (valid_c[i]),
      .task_id     (task_c[i]),
      .key         (key_c[i]),
      .ins_le      (le_c[i]),
      .found_out   (found_c[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      popped    <= ctl.pop_en ? task_c[0] : '0;
      count_out <= count_next;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_out};
  assign m_tuser   = status;
  assign m_tdata   = {{(M_DATA_W - TASK_W - COUNT_W){1'b0}}, count_ext[COUNT_W-1:0], popped};

endmodule

### test/testbench.sv
// Self-checking testbench for the sorted runtime priority queue stream block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srpq_pkg::*;

  localparam int DEPTH       = DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 2000;
  localparam int IDLE_PCT    = 13;

  typedef struct {
    status_t           status;
    logic [TASK_W-1:0]  popped;
    logic [COUNT_W-1:0] count;
  } queue_reply_t;

  typedef struct {
    op_t              op;
    logic [TASK_W-1:0] tid;
    logic [RT_W-1:0]   key;
    int               reps;
    bit               typed;
    queue_reply_t     want;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  // Typed-in reply that travels alongside the request currently presented.
  bit                    row_typed = 1'b0;
  queue_reply_t          row_want = '{ST_DONE, '0, '0};

  // Shadow copy of the sorted store.
  logic [TASK_W-1:0]     shadow_id [DEPTH];
  logic [RT_W-1:0]       shadow_key [DEPTH];
  int                    shadow_held = 0;

  queue_reply_t          replies_due[$];
  plan_row_t             plan[$];
  logic [TASK_W-1:0]     recent_ids[$];
  bit                    calm = 1'b0;
  int                    errors = 0;
  int                    accepted = 0;
  int                    replies_seen = 0;
  int                    full_seen = 0;
  int                    miss_seen = 0;
  int                    pops_seen = 0;
  int                    cycles = 0;

  sorted_runtime_priority_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic queue_reply_t apply_to_shadow(op_t op, logic [TASK_W-1:0] tid,
                                                   logic [RT_W-1:0] key);
    queue_reply_t res;
    int pos;
    int drop_at;
    res = '{ST_DONE, '0, '0};
    drop_at = -1;
    case (op)
      OP_INSERT: begin
        if (shadow_held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // New entry goes ahead of the first entry with an equal or larger key.
          pos = shadow_held;
          for (int i = shadow_held - 1; i >= 0; i--)
            if (key <= shadow_key[i]) pos = i;
          for (int i = shadow_held; i > pos; i--) begin
            shadow_id[i]  = shadow_id[i-1];
            shadow_key[i] = shadow_key[i-1];
          end
          shadow_id[pos]  = tid;
          shadow_key[pos] = key;
          shadow_held++;
        end
      end
      OP_POP: begin
        if (shadow_held == 0) begin
          res.status = ST_MISS;
        end else begin
          res.popped = shadow_id[0];
          drop_at = 0;
        end
      end
      OP_REMOVE: begin
        for (int i = shadow_held - 1; i >= 0; i--)
          if (shadow_id[i] == tid) drop_at = i;
        if (drop_at < 0) res.status = ST_MISS;
      end
      default: ;
    endcase
    if (drop_at >= 0) begin
      for (int i = drop_at; i + 1 < shadow_held; i++) begin
        shadow_id[i]  = shadow_id[i+1];
        shadow_key[i] = shadow_key[i+1];
      end
      shadow_held--;
    end
    res.count = COUNT_W'(shadow_held);
    return res;
  endfunction

  function automatic plan_row_t mk_row(op_t op, logic [TASK_W-1:0] tid, logic [RT_W-1:0] key,
                                       int reps, bit typed, status_t st,
                                       logic [TASK_W-1:0] popped, logic [COUNT_W-1:0] count);
    plan_row_t r;
    r.op    = op;
    r.tid   = tid;
    r.key   = key;
    r.reps  = reps;
    r.typed = typed;
    r.want  = '{st, popped, count};
    return r;
  endfunction

  task automatic issue_request(op_t op, logic [TASK_W-1:0] tid, logic [RT_W-1:0] key,
                               bit typed, queue_reply_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= op;
    s_tdata   <= {{(S_DATA_W - TASK_W - RT_W){1'b0}}, key, tid};
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : watch
    queue_reply_t want;
    queue_reply_t pred;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        replies_seen++;
        if (m_tuser == ST_FULL) full_seen++;
        if (m_tuser == ST_MISS) miss_seen++;
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding: status %0d", m_tuser);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            errors++;
          end
          if (m_tdata[TASK_W-1:0] !== want.popped) begin
            $error("popped_task: expected %0d, got %0d", want.popped, m_tdata[TASK_W-1:0]);
            errors++;
          end
          if (m_tdata[TASK_W +: COUNT_W] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count,
                   m_tdata[TASK_W +: COUNT_W]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        accepted++;
        if (op_t'(s_tuser) == OP_POP) pops_seen++;
        pred = apply_to_shadow(op_t'(s_tuser), s_tdata[TASK_W-1:0], s_tdata[TASK_W +: RT_W]);
        replies_due.push_back(row_typed ? row_want : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, replies_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t    r;
    queue_reply_t dummy;
    op_t          op;
    logic [TASK_W-1:0] tid;
    logic [RT_W-1:0]   key;
    int           pick;
    bit           filling;

    dummy = '{ST_DONE, '0, '0};
    plan.push_back(mk_row(OP_POP,    4'd0,  32'h0,         1,  1, ST_MISS, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_REMOVE, 4'd5,  32'h0,         1,  1, ST_MISS, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_NONE,   4'd15, 32'hFFFF_FFFF, 1,  1, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_INSERT, 4'd15, 32'hFFFF_FFFF, 1,  1, ST_DONE, 4'd0, 5'd1));
    plan.push_back(mk_row(OP_INSERT, 4'd0,  32'h0,         1,  1, ST_DONE, 4'd0, 5'd2));
    // An equal key must land ahead of the older entry.
    plan.push_back(mk_row(OP_INSERT, 4'd7,  32'h0,         1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_INSERT, 4'd9,  32'h1234_5678, 1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_POP,    4'd0,  32'h0,         1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_REMOVE, 4'd9,  32'h0,         1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_REMOVE, 4'd9,  32'h0,         1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_POP,    4'd0,  32'h0,         2,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_POP,    4'd0,  32'h0,         1,  1, ST_MISS, 4'd0, 5'd0));
    // Fill the store with duplicate ids and keys, then hit the full limit.
    plan.push_back(mk_row(OP_INSERT, 4'd3,  32'h8000_0000, 16, 0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_INSERT, 4'd12, 32'h1,         1,  1, ST_FULL, 4'd0, 5'd16));
    plan.push_back(mk_row(OP_NONE,   4'd0,  32'h0,         1,  1, ST_DONE, 4'd0, 5'd16));
    plan.push_back(mk_row(OP_REMOVE, 4'd3,  32'h0,         1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_INSERT, 4'd10, 32'h8000_0000, 1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_POP,    4'd0,  32'h0,         1,  0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_REMOVE, 4'd3,  32'h0,         15, 0, ST_DONE, 4'd0, 5'd0));
    plan.push_back(mk_row(OP_REMOVE, 4'd3,  32'h0,         1,  1, ST_MISS, 4'd0, 5'd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      repeat (r.reps) issue_request(r.op, r.tid, r.key, r.typed, r.want);
    end

    // Alternate fill-heavy and drain-heavy stretches so the store swings
    // between empty and full.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm    = (n >= 900 && n < 1200);
      filling = ((n / 150) % 2) == 0;
      pick    = $urandom_range(99);
      if (pick < (filling ? 65 : 25))      op = OP_INSERT;
      else if (pick < (filling ? 80 : 60)) op = OP_POP;
      else if (pick < (filling ? 97 : 95)) op = OP_REMOVE;
      else                                 op = OP_NONE;
      tid = TASK_W'($urandom_range(15));
      case ($urandom_range(3))
        0:       key = $urandom_range(7);
        1:       key = $urandom;
        2: begin
          case ($urandom_range(3))
            0:       key = 32'h0;
            1:       key = 32'hFFFF_FFFF;
            2:       key = 32'h7FFF_FFFF;
            default: key = 32'h8000_0000;
          endcase
        end
        default: key = $urandom_range(1000);
      endcase
      if (op == OP_INSERT) begin
        recent_ids.push_back(tid);
        if (recent_ids.size() > 8) void'(recent_ids.pop_front());
      end else if (op == OP_REMOVE && recent_ids.size() > 0 && $urandom_range(9) < 7) begin
        tid = recent_ids[$urandom_range(recent_ids.size() - 1)];
      end
      issue_request(op, tid, key, 1'b0, dummy);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Accepted %0d requests (%0d pops) and checked %0d replies.",
             accepted, pops_seen, replies_seen);
    $display("Replies flagged full: %0d, empty or not found: %0d.", full_seen, miss_seen);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/srpq_pkg.sv
rtl/srpq_cell.sv
rtl/sorted_runtime_priority_queue.sv
test/testbench.sv
